/* design/integer_to_radix_ascii_macros.svh */
// Assertion macros shared by the RTL files.
`ifndef INTEGER_TO_RADIX_ASCII_MACROS_SVH
`define INTEGER_TO_RADIX_ASCII_MACROS_SVH

`ifndef SYNTHESIS

// Property holds at every clock edge outside reset.
`define ITRA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");

// Condition never holds outside reset.
`define ITRA_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define ITRA_ASSERT(lbl, clk, rstn, prop)
`define ITRA_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

/* design/itra_pkg.sv */
package itra_pkg;

  // Width of the converted value
  localparam int unsigned ValueBits = 32;
  // Digit counter holds 0..ValueBits
  localparam int unsigned CntW      = $clog2(ValueBits + 1);
  // Divider step counter holds 0..ValueBits-1
  localparam int unsigned StepW     = $clog2(ValueBits);

  localparam logic [3:0] RadixMin   = 4'd2;
  localparam logic [3:0] RadixMax   = 4'd10;
  localparam logic [3:0] RadixReset = 4'd10;

  localparam logic [7:0] AsciiZero  = 8'd48;
  localparam logic [7:0] AsciiMinus = 8'd45;

  // Divider status toward the sequencer
  typedef struct packed {
    logic done;       // one-cycle pulse: quotient and remainder valid
    logic quot_zero;  // quotient is zero
  } itra_div_stat_t;

endpackage

/* design/itra_div.sv */
`include "integer_to_radix_ascii_macros.svh"

// Bit-serial restoring divider: one quotient bit per cycle.
module itra_div import itra_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [ValueBits-1:0] dividend_i,
  input  logic [3:0]           divisor_i,
  output itra_div_stat_t       stat_o,
  output logic [ValueBits-1:0] quotient_o,
  output logic [3:0]           remainder_o
);

  logic [ValueBits-1:0] acc_q, acc_d;   // dividend shifts out, quotient shifts in
  logic [3:0]           rem_q, rem_d;
  logic [StepW-1:0]     step_q, step_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;

  logic [4:0] shifted;
  logic [4:0] diff;
  logic       fits;

  // One restoring step
  always_comb begin
    shifted = {rem_q, acc_q[ValueBits-1]};
    diff    = shifted - {1'b0, divisor_i};
    fits    = (shifted >= {1'b0, divisor_i});
  end

  always_comb begin
    acc_d  = acc_q;
    rem_d  = rem_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d  = dividend_i;
      rem_d  = '0;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d  = {acc_q[ValueBits-2:0], fits};
      rem_d  = fits ? diff[3:0] : shifted[3:0];
      step_d = step_q + 1'b1;
      if (step_q == StepW'(ValueBits - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
  end

  assign stat_o.done      = done_q;
  assign stat_o.quot_zero = (acc_q == '0);
  assign quotient_o       = acc_q;
  assign remainder_o      = rem_q;

  `ITRA_ASSERT_NEVER(a_start_busy, clk_i, rst_ni, start_i && busy_q)
  `ITRA_ASSERT(a_done_after_busy, clk_i, rst_ni, done_q |-> $past(busy_q) && !busy_q)
  `ITRA_ASSERT(a_rem_below_div, clk_i, rst_ni, done_q |-> rem_q < divisor_i)

endmodule

/* design/integer_to_radix_ascii.sv */
// Channel  | Direction | Handshake              | Payload
// input    | in        | in_valid_i/in_ready_o  | value_i (32 b, signed)
// output   | out       | out_valid_o/out_ready_i| character_o (8 b), last_o
// config   | in        | APB psel/penable/pready| radix at byte address 0
//
// Each digit takes one full pass of the bit-serial divider, so a value with n
// digits is divided n times; then the text goes out at one character per cycle
// (sign plus n digits) while the output is not stalled.
// Reset clears control state and sets radix to 10; the digit stack is not reset.
// A stalled output only holds the character sequencer; the next value is
// accepted once the last character of the current one is in the output register.
`include "integer_to_radix_ascii_macros.svh"

module integer_to_radix_ascii import itra_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input transaction
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [ValueBits-1:0] value_i,
  // output transaction
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [7:0]                  character_o,
  output logic                        last_o,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam logic RegRadixIdx = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_SIGN = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic [3:0]           radix_q;
  logic [3:0]           radix_eff;
  logic                 neg_q, neg_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [3:0]           stack_q [ValueBits];
  logic                 push, pop;
  logic                 out_valid_q, out_valid_d;
  logic [7:0]           char_q, char_d;
  logic                 last_q, last_d;
  logic                 slot_free;
  logic                 in_acc;
  logic [ValueBits-1:0] magnitude;
  logic                 div_start;
  logic [ValueBits-1:0] div_dividend;
  itra_div_stat_t       div_stat;
  logic [ValueBits-1:0] div_quot;
  logic [3:0]           div_rem;

  // Config register
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RadixReset;
    end else if (psel && penable && pwrite && (paddr[2] == RegRadixIdx)) begin
      radix_q <= pwdata[3:0];
    end
  end
  assign prdata = (paddr[2] == RegRadixIdx) ? 32'(radix_q) : '0;

  // Clamp radix to 2..10
  always_comb begin
    priority if (radix_q < RadixMin) begin
      radix_eff = RadixMin;
    end else if (radix_q > RadixMax) begin
      radix_eff = RadixMax;
    end else begin
      radix_eff = radix_q;
    end
  end

  // Magnitude as unsigned, most negative value included
  assign magnitude = value_i[ValueBits-1] ? (~value_i + ValueBits'(1)) : value_i;

  assign in_ready_o   = (state_q == S_IDLE);
  assign in_acc       = in_valid_i && in_ready_o;
  assign slot_free    = !out_valid_q || out_ready_i;
  assign div_start    = in_acc || (div_stat.done && !div_stat.quot_zero);
  assign div_dividend = in_acc ? magnitude : div_quot;

  itra_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (radix_eff),
    .stat_o      (div_stat),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  // Sequencer and output register
  always_comb begin
    state_d     = state_q;
    neg_d       = neg_q;
    cnt_d       = cnt_q;
    push        = 1'b0;
    pop         = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    char_d      = char_q;
    last_d      = last_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          neg_d   = value_i[ValueBits-1];
          cnt_d   = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          push  = 1'b1;
          cnt_d = cnt_q + 1'b1;
          if (div_stat.quot_zero) begin
            state_d = neg_q ? S_SIGN : S_EMIT;
          end
        end
      end
      S_SIGN: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          char_d      = AsciiMinus;
          last_d      = 1'b0;
          state_d     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          pop         = 1'b1;
          out_valid_d = 1'b1;
          char_d      = AsciiZero + {4'b0000, stack_q[0]};
          last_d      = (cnt_q == CntW'(1));
          cnt_d       = cnt_q - 1'b1;
          if (cnt_q == CntW'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      neg_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      neg_q       <= neg_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
  end

  // Digit stack: push at entry 0, pop from entry 0
  always_ff @(posedge clk_i) begin
    if (push) begin
      stack_q[0] <= div_rem;
      for (int i = 1; i < ValueBits; i++) begin
        stack_q[i] <= stack_q[i-1];
      end
    end else if (pop) begin
      for (int i = 0; i < ValueBits - 1; i++) begin
        stack_q[i] <= stack_q[i+1];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

  `ITRA_ASSERT(a_done_in_div, clk_i, rst_ni, div_stat.done |-> state_q == S_DIV)
  `ITRA_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= CntW'(ValueBits))
  `ITRA_ASSERT_NEVER(a_emit_empty, clk_i, rst_ni, (state_q == S_EMIT) && (cnt_q == '0))
  `ITRA_ASSERT(a_accept_starts, clk_i, rst_ni, in_acc |=> state_q == S_DIV)

endmodule

/* tb/radix_text_checker.sv */
// Watches the value, text and register ports of integer_to_radix_ascii,
// predicts the text of every accepted value and compares each character.
module radix_text_checker import itra_pkg::*; #(
  parameter logic [2:0] RadixAddr = 3'd0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_o,
  input  logic signed [ValueBits-1:0] value_i,
  input  logic                        out_valid_o,
  input  logic                        out_ready_i,
  input  logic [7:0]                  character_o,
  input  logic                        last_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output int unsigned                 mismatch_count,
  output int unsigned                 pending_chars,
  output int unsigned                 values_seen,
  output int unsigned                 chars_seen
);

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } text_char_t;

  logic [3:0] radix_q;
  text_char_t text_q[$];

  // Append the expected text of one value to the queue
  function automatic void spell_value(logic [ValueBits-1:0] bits, logic [3:0] radix_reg);
    logic [ValueBits-1:0] mag;
    logic [ValueBits-1:0] base;
    logic [3:0]           digits[ValueBits];
    int                   n;
    text_char_t           c;
    if (radix_reg < RadixMin) begin
      base = RadixMin;
    end else if (radix_reg > RadixMax) begin
      base = RadixMax;
    end else begin
      base = radix_reg;
    end
    // magnitude as unsigned, so the most negative value needs no extra bit
    mag = bits[ValueBits-1] ? (~bits + 1'b1) : bits;
    n = 0;
    do begin
      digits[n] = 4'(mag % base);
      n++;
      mag = mag / base;
    end while (mag != 0);
    if (bits[ValueBits-1]) begin
      c.character = AsciiMinus;
      c.last      = 1'b0;
      text_q.push_back(c);
    end
    // most significant digit first
    for (int i = n - 1; i >= 0; i--) begin
      c.character = AsciiZero + 8'(digits[i]);
      c.last      = (i == 0);
      text_q.push_back(c);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    text_char_t want;
    if (!rst_ni) begin
      radix_q = RadixReset;
      text_q.delete();
      mismatch_count = 0;
      values_seen = 0;
      chars_seen = 0;
    end else begin
      // register write; other addresses hold nothing
      if (psel && penable && pwrite && pready && paddr == RadixAddr) begin
        radix_q = pwdata[3:0];
      end
      // character transaction
      if (out_valid_o && out_ready_i) begin
        chars_seen++;
        if (text_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected character %0d last %0b, nothing expected",
                   $time, character_o, last_o);
        end else begin
          want = text_q.pop_front();
          if (character_o !== want.character) begin
            mismatch_count++;
            $display("%0t: character expected %0d got %0d",
                     $time, want.character, character_o);
          end
          if (last_o !== want.last) begin
            mismatch_count++;
            $display("%0t: last expected %0b got %0b", $time, want.last, last_o);
          end
        end
      end
      // value transaction
      if (in_valid_i && in_ready_o) begin
        values_seen++;
        spell_value(value_i, radix_q);
      end
    end
    pending_chars = text_q.size();
  end

endmodule

/* tb/integer_to_radix_ascii_test.sv */
// Drives values and radix settings into integer_to_radix_ascii; the checker
// beside the block predicts and compares the text.
module integer_to_radix_ascii_test;
  import itra_pkg::*;

  localparam logic [2:0]  RadixAddr     = 3'd0;
  localparam logic [2:0]  SpareAddr     = 3'd4;  // no register behind it
  localparam int unsigned CycleLimit    = 2_000_000;
  localparam int unsigned DrainCycles   = 1200;  // longest conversion plus margin
  localparam int unsigned IdlePct       = 17;
  localparam int unsigned ItemsPerPhase = 17;
  localparam int unsigned NumPhases     = 16;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic signed [ValueBits-1:0] value_i     = '0;
  logic                        out_ready_i = 1'b0;
  logic                        psel        = 1'b0;
  logic                        penable     = 1'b0;
  logic                        pwrite      = 1'b0;
  logic [2:0]                  paddr       = '0;
  logic [31:0]                 pwdata      = '0;
  logic                        in_ready_o;
  logic                        out_valid_o;
  logic [7:0]                  character_o;
  logic                        last_o;
  logic [31:0]                 prdata;
  logic                        pready;

  logic        steady_flow = 1'b0;  // no idling on either side while set
  logic [3:0]  radix_set   = RadixReset;
  int unsigned writes_done = 0;
  int unsigned cycle_count;
  int unsigned mismatch_count, pending_chars, values_seen, chars_seen;

  // register values swept by the random phases, out-of-range ones included
  logic [3:0] phase_radix[NumPhases] =
    '{4'd2, 4'd0, 4'd1, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15};

  logic [31:0] decimal_cases[10] =
    '{32'd0, 32'd1, 32'hffff_ffff, 32'd9, 32'd10, -32'sd10,
      32'h7fff_ffff, 32'h8000_0000, 32'd1_000_000_000, -32'sd999};
  logic [31:0] binary_cases[5] =
    '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'd0, 32'd1};

  integer_to_radix_ascii uut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .value_i,
    .out_valid_o, .out_ready_i, .character_o, .last_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  radix_text_checker #(.RadixAddr(RadixAddr)) checker_i (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .value_i,
    .out_valid_o, .out_ready_i, .character_o, .last_o,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .mismatch_count, .pending_chars, .values_seen, .chars_seen
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // output stalls
  always @(posedge clk_i) begin
    out_ready_i <= steady_flow || ($urandom_range(0, 99) >= IdlePct);
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // one value transaction, with random gaps ahead of it
  task automatic send_value(input logic [31:0] v);
    while (!steady_flow && $urandom_range(0, 99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // drop valid and wait until every expected character has come out
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_chars != 0);
    @(posedge clk_i);
  endtask

  // APB write: setup then access; upper data bits carry noise
  task automatic write_reg(input logic [2:0] addr, input logic [3:0] data);
    logic [31:0] word;
    word      = $urandom();
    word[3:0] = data;
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == RadixAddr) begin
      radix_set = data;
    end
    writes_done++;
  endtask

  // random value: small, near powers of the base, extremes, narrow or full
  function automatic logic [31:0] pick_value();
    logic [31:0]     v;
    longint unsigned p;
    int unsigned     base;
    base = (radix_set < RadixMin) ? RadixMin : (radix_set > RadixMax) ? RadixMax : radix_set;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 99);
      1: begin
        p = 1;
        repeat ($urandom_range(1, 31)) begin
          if (p * base <= 64'h8000_0000) p = p * base;
        end
        v = 32'(p) + $urandom_range(0, 2) - 1;
      end
      2: begin
        case ($urandom_range(0, 3))
          0:       v = '0;
          1:       v = 32'h7fff_ffff;
          2:       v = 32'h8000_0000;
          default: v = 32'h8000_0001;
        endcase
      end
      3: v = $urandom() >> $urandom_range(1, 31);
      default: v = $urandom();
    endcase
    if ($urandom_range(0, 1) == 0) v = -v;
    return v;
  endfunction

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: decimal at the reset radix
    foreach (decimal_cases[i]) send_value(decimal_cases[i]);
    // directed: binary, longest texts
    write_reg(RadixAddr, 4'd2);
    foreach (binary_cases[i]) send_value(binary_cases[i]);
    // radix below two behaves as binary
    write_reg(RadixAddr, 4'd0);
    send_value(32'h8000_0000);
    // radix above ten behaves as decimal
    write_reg(RadixAddr, 4'd15);
    send_value(32'h8000_0000);
    send_value(32'd123);
    // write to an unused address leaves the radix alone
    write_reg(SpareAddr, 4'd3);
    send_value(32'd100);
    write_reg(RadixAddr, 4'd9);
    send_value(-32'sd80);

    // random phases over every register value
    for (int ph = 0; ph < NumPhases; ph++) begin
      write_reg(RadixAddr, phase_radix[ph]);
      if (ph == 5) write_reg(SpareAddr, 4'($urandom()));
      steady_flow <= (ph == 7 || ph == 8);
      repeat (ItemsPerPhase) send_value(pick_value());
    end

    wait_idle();
    steady_flow <= 1'b0;
    repeat (DrainCycles) @(posedge clk_i);

    $display("Converted %0d values into %0d characters over %0d register writes",
             values_seen, chars_seen, writes_done);
    $display("Register values 0 to 15 applied, extremes in binary and decimal included");
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
